FILE: src/two_key_min_heap_queue_defines.svh
// Assertion macros used by the heap queue core module.
`ifndef TWO_KEY_MIN_HEAP_QUEUE_DEFINES_SVH
`define TWO_KEY_MIN_HEAP_QUEUE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TKMH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define TKMH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/tkmh_pkg.sv
// Types, codes and the entry ordering function of the two-key min-heap queue.
package tkmh_pkg;

	localparam int TIME_W = 31;
	localparam int TAG_W = 31;
	localparam int HANDLE_W = 32;
	localparam int OCC_W = 7;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_FETCH,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [TAG_W-1:0] key_tag;
		logic [TIME_W-1:0] key_time;
	} entry_t;

	typedef struct packed {
		op_t op;
		entry_t entry;
	} req_t;

	typedef struct packed {
		status_t status;
		entry_t entry;
		logic [OCC_W-1:0] occupancy;
	} res_t;

	// a strictly less than b: lower timestamp, then lower tag
	function automatic logic entry_less(entry_t a, entry_t b);
		return (a.key_time < b.key_time) ||
			((a.key_time == b.key_time) && (a.key_tag < b.key_tag));
	endfunction

endpackage

FILE: src/two_key_min_heap_queue.sv
// Top level of the two-key min-heap queue: stream ports and result register.
//
//  channel  | direction | fields
//  s_*      | in        | tuser: op; tdata: key_time, key_tag, handle
//  m_*      | out       | tuser: status; tdata: out_time, out_tag, out_handle, occupancy
//
// One transaction at a time. An insert walks up from the new last position and an extract
// walks down from the root; each level the entry moves (at most log2(CAPACITY) levels)
// is one memory read state plus one compare/write state. An insert that reaches the root
// and an extract that reaches a leaf write without a final compare; an extract that empties
// the heap goes from the root fetch straight to the result.
// Refused operations (full insert, empty extract) go straight to the result.
// Reset empties the heap at once; no clearing pass.
// A result held in the output register does not block the next input transaction.
module two_key_min_heap_queue #(
	parameter int CAPACITY = 64
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [95:0] s_tdata, // key_time[30:0], key_tag[61:31], handle[93:62], zero fill
	input logic [0:0] s_tuser, // op[0]
	output logic m_tvalid,
	input logic m_tready,
	output logic [103:0] m_tdata, // out_time[30:0], out_tag[61:31], out_handle[93:62],
	                              // occupancy[100:94], zero fill
	output logic [1:0] m_tuser // status[1:0]
);
	import tkmh_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	req_t req;
	res_t core_res;
	res_t res_q;
	logic core_idle;
	logic core_res_valid;
	logic res_take;
	logic m_tvalid_q;

	assign req.op = op_t'(s_tuser[0]);
	assign req.entry.key_time = s_tdata[30:0];
	assign req.entry.key_tag = s_tdata[61:31];
	assign req.entry.handle = s_tdata[93:62];

	assign s_tready = core_idle;
	// take a finished result when the output register is empty or draining
	assign res_take = !m_tvalid_q || m_tready;

	tkmh_core #(
		.CAPACITY(CAPACITY),
		.AW(AW),
		.CW(CW)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.start(s_tvalid && s_tready),
		.req(req),
		.idle(core_idle),
		.res_valid(core_res_valid),
		.res(core_res),
		.res_take(res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (core_res_valid && res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_valid && res_take) begin
			res_q <= core_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser = res_q.status;
	assign m_tdata = {3'b000, res_q.occupancy, res_q.entry.handle,
		res_q.entry.key_tag, res_q.entry.key_time};

endmodule

FILE: src/tkmh_mem.sv
// Heap entry storage: one write port, two read ports with registered read data.
module tkmh_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input tkmh_pkg::entry_t wdata,
	input logic [AW-1:0] raddr_a,
	input logic [AW-1:0] raddr_b,
	output tkmh_pkg::entry_t rdata_a,
	output tkmh_pkg::entry_t rdata_b
);
	import tkmh_pkg::*;

	entry_t mem_q [0:DEPTH-1];
	entry_t rdata_a_q;
	entry_t rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

FILE: src/tkmh_core.sv
// Heap sequencer: count register, sift-up and sift-down walks over the entry memory.
module tkmh_core #(
	parameter int CAPACITY = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input tkmh_pkg::req_t req,
	output logic idle,
	output logic res_valid,
	output tkmh_pkg::res_t res,
	input logic res_take
);
	import tkmh_pkg::*;

	`include "two_key_min_heap_queue_defines.svh"

	localparam int LW = AW + 1;

	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	entry_t mv_q;
	entry_t out_q;
	status_t status_q;

	logic we;
	logic [AW-1:0] waddr;
	entry_t wdata;
	logic [AW-1:0] raddr_a, raddr_b;
	entry_t rdata_a, rdata_b;

	logic full;
	logic empty;
	logic [CW-1:0] last_idx;
	logic [AW-1:0] parent;
	logic [LW-1:0] lidx, ridx, cnt_l;
	logic l_in, r_in;
	logic pick_r;
	entry_t child;
	logic [AW-1:0] child_idx;
	logic up_move, dn_move;

	assign full = count_q == CW'(CAPACITY);
	assign empty = count_q == '0;
	assign last_idx = count_q - CW'(1);
	assign parent = AW'((pos_q - AW'(1)) >> 1);
	assign lidx = {pos_q, 1'b1};
	assign ridx = lidx + LW'(1);
	assign cnt_l = LW'(count_q);
	assign l_in = lidx < cnt_l;
	assign r_in = ridx < cnt_l;
	// right child wins ties
	assign pick_r = r_in && !entry_less(rdata_a, rdata_b);
	assign child = pick_r ? rdata_b : rdata_a;
	assign child_idx = pick_r ? ridx[AW-1:0] : lidx[AW-1:0];
	assign up_move = entry_less(mv_q, rdata_a);
	assign dn_move = entry_less(child, mv_q);

	tkmh_mem #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.op == OP_INSERT) begin
						state_d = full ? S_DONE : S_UP_RD;
					end else begin
						state_d = empty ? S_DONE : S_DN_FETCH;
					end
				end
			end
			S_UP_RD: state_d = (pos_q == '0) ? S_DONE : S_UP_CMP;
			S_UP_CMP: state_d = up_move ? S_UP_RD : S_DONE;
			S_DN_FETCH: state_d = empty ? S_DONE : S_DN_RD;
			S_DN_RD: state_d = l_in ? S_DN_CMP : S_DONE;
			S_DN_CMP: state_d = dn_move ? S_DN_RD : S_DONE;
			S_DONE: state_d = res_take ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		wdata = mv_q;
		raddr_a = '0;
		raddr_b = '0;
		case (state_q)
			S_IDLE: begin
				// fetch root and last entry for a possible extract
				raddr_a = '0;
				raddr_b = last_idx[AW-1:0];
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					raddr_a = parent;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (up_move) begin
					wdata = rdata_a;
				end
			end
			S_DN_RD: begin
				if (l_in) begin
					raddr_a = lidx[AW-1:0];
					raddr_b = r_in ? ridx[AW-1:0] : lidx[AW-1:0];
				end else begin
					we = 1'b1;
				end
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (dn_move) begin
					wdata = child;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				if (req.op == OP_INSERT && !full) begin
					count_q <= count_q + CW'(1);
				end else if (req.op == OP_EXTRACT && !empty) begin
					count_q <= last_idx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					out_q <= '0;
					mv_q <= req.entry;
					pos_q <= count_q[AW-1:0];
					if (req.op == OP_INSERT) begin
						status_q <= full ? ST_FULL : ST_OK;
					end else begin
						status_q <= empty ? ST_EMPTY : ST_OK;
					end
				end
			end
			S_UP_CMP: begin
				if (up_move) begin
					pos_q <= parent;
				end
			end
			S_DN_FETCH: begin
				out_q <= rdata_a;
				mv_q <= rdata_b;
				pos_q <= '0;
			end
			S_DN_CMP: begin
				if (dn_move) begin
					pos_q <= child_idx;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign idle = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res.status = status_q;
	assign res.entry = out_q;
	assign res.occupancy = OCC_W'(count_q);

	`TKMH_ASSERT_IMP(a_count_range, 1'b1, count_q <= CW'(CAPACITY),
		"entry count above capacity")
	`TKMH_ASSERT_IMP(a_write_in_sift, we,
		state_q == S_UP_RD || state_q == S_UP_CMP || state_q == S_DN_RD || state_q == S_DN_CMP,
		"memory write outside a sift walk")
	`TKMH_ASSERT_IMP(a_hole_in_heap, state_q == S_DN_RD || state_q == S_UP_CMP,
		CW'(pos_q) < count_q, "sift position beyond entry count")
	`TKMH_ASSERT_NXT(a_full_refused,
		state_q == S_IDLE && start && req.op == OP_INSERT && full,
		state_q == S_DONE && $stable(count_q), "insert into full heap changed state")
	`TKMH_ASSERT_NXT(a_empty_refused,
		state_q == S_IDLE && start && req.op == OP_EXTRACT && empty,
		state_q == S_DONE && $stable(count_q), "extract from empty heap changed state")

endmodule
